### design/bic_pkg.sv
package bic_pkg;

  // line buffer
  localparam int MAX_LINES   = 64;
  localparam int LINE_AW     = $clog2(MAX_LINES);
  localparam int CNT_W       = LINE_AW + 1;
  localparam int LINE_EXTENT = 645;

  // datapath widths
  localparam int COORD_W = 24;
  localparam int C_W     = 36;
  localparam int PROD_W  = C_W + COORD_W;
  localparam int ANG_W   = 19;
  localparam int NUM_W   = 58;
  localparam int DEN_W   = 36;
  localparam int STEP_W  = 6;
  localparam int SUM_W   = 23;
  localparam int PCNT_W  = 12;
  localparam int QDEPTH  = 2;
  localparam int QAW     = $clog2(QDEPTH);

  // cordic
  localparam int CORDIC_STEPS = 16;
  localparam int CIDX_W       = $clog2(CORDIC_STEPS);
  localparam int CORDIC_SCALE = 20;
  localparam int CORDIC_W     = 46;

  localparam int ANGLE_LIMIT     = 74868;
  localparam int ONE_RADIAN      = 65536;
  localparam int FRONT_DIV_STEPS = 23;

  typedef struct packed {
    logic [9:0] xs;
    logic [9:0] ys;
    logic [9:0] xe;
    logic [9:0] ye;
    logic       last;
  } seg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] dx;
    logic signed [COORD_W-1:0] dy;
    logic signed [C_W-1:0]     c;
    logic signed [ANG_W-1:0]   ang;
  } line_t;

  typedef struct packed {
    line_t line;
    logic  last;
  } qentry_t;

  typedef struct packed {
    logic                    start;
    logic signed [NUM_W-1:0] num;
    logic signed [DEN_W-1:0] den;
    logic [STEP_W-1:0]       steps;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [NUM_W-1:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic [9:0]        cx;
    logic [9:0]        cy;
    logic [PCNT_W-1:0] count;
    logic              overflow;
  } result_t;

  typedef enum logic [3:0] {
    F_IDLE, F_NUM, F_D1GO, F_D1W, F_D3GO, F_D3W, F_C1, F_C2, F_ROT, F_PUSH
  } front_state_t;

  typedef enum logic [4:0] {
    B_IDLE, B_START, B_RDI, B_GETI, B_RDJ, B_GETJ, B_MUL, B_CHK,
    B_DXGO, B_DXW, B_DYGO, B_DYW, B_NEXT,
    B_MEANX, B_MXW, B_MYGO, B_MYW, B_OUT
  } back_state_t;

  // arctangent of 2^-i in Q16 radians, rounded
  function automatic logic signed [ANG_W-1:0] atan_tab(input logic [CIDX_W-1:0] idx);
    logic signed [ANG_W-1:0] v;
    case (idx)
      4'd0:    v = 19'sd51472;
      4'd1:    v = 19'sd30386;
      4'd2:    v = 19'sd16055;
      4'd3:    v = 19'sd8150;
      4'd4:    v = 19'sd4091;
      4'd5:    v = 19'sd2047;
      4'd6:    v = 19'sd1024;
      4'd7:    v = 19'sd512;
      4'd8:    v = 19'sd256;
      4'd9:    v = 19'sd128;
      4'd10:   v = 19'sd64;
      4'd11:   v = 19'sd32;
      4'd12:   v = 19'sd16;
      4'd13:   v = 19'sd8;
      4'd14:   v = 19'sd4;
      4'd15:   v = 19'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### design/bic_div.sv
module bic_div (
  input  logic              clk,
  input  logic              rst,
  input  bic_pkg::div_req_t req,
  output bic_pkg::div_rsp_t rsp
);
  import bic_pkg::*;

  logic              busy;
  logic              done_r;
  logic              neg;
  logic [STEP_W-1:0] left;
  logic [DEN_W:0]    rem;
  logic [NUM_W-1:0]  q;
  logic [DEN_W-1:0]  dmag;

  logic [NUM_W-1:0]  num_mag;
  logic [DEN_W-1:0]  den_mag;
  logic [STEP_W-1:0] sh;
  logic [DEN_W:0]    rem_sh;
  logic              ge;
  logic [DEN_W:0]    rem_nx;

  // operand magnitudes, numerator aligned so only the needed steps run
  always_comb begin
    num_mag = req.num[NUM_W-1] ? -req.num : req.num;
    den_mag = req.den[DEN_W-1] ? -req.den : req.den;
    sh      = STEP_W'(NUM_W) - req.steps;
    rem_sh  = {rem[DEN_W-1:0], q[NUM_W-1]};
    ge      = rem_sh >= {1'b0, dmag};
    rem_nx  = ge ? rem_sh - {1'b0, dmag} : rem_sh;
  end

  // restoring divide, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        left <= req.steps;
        rem  <= '0;
        q    <= num_mag << sh;
        dmag <= den_mag;
        neg  <= req.num[NUM_W-1] ^ req.den[DEN_W-1];
      end else if (busy) begin
        rem  <= rem_nx;
        q    <= {q[NUM_W-2:0], ge};
        left <= left - 1'b1;
        if (left == STEP_W'(1)) begin
          busy   <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // quotient truncated toward zero
  always_comb begin
    rsp.done = done_r;
    rsp.quo  = neg ? -$signed(q) : $signed(q);
  end

endmodule

### design/bic_front.sv
module bic_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  bic_pkg::seg_t     in_seg,
  output logic              push,
  output bic_pkg::qentry_t  push_entry,
  input  logic              q_full,
  output bic_pkg::div_req_t div_req,
  input  bic_pkg::div_rsp_t div_rsp
);
  import bic_pkg::*;

  localparam logic signed [COORD_W-1:0] EXT_S = COORD_W'(LINE_EXTENT);
  localparam logic signed [COORD_W-1:0] NEG1  = COORD_W'(-1);
  localparam logic signed [COORD_W-1:0] ONE_C = COORD_W'(1);

  front_state_t state, state_next;

  seg_t                       seg;
  logic signed [COORD_W-1:0]  n1, n3;
  logic signed [COORD_W-1:0]  a0, a1, a2, a3;
  logic signed [C_W-1:0]      cp, c;
  logic signed [CORDIC_W-1:0] cx, cy;
  logic signed [ANG_W-1:0]    z, ang;
  logic [CIDX_W-1:0]          cidx;
  logic                       neg;

  logic [10:0]                sum_xx, sum_yy;
  logic signed [COORD_W-1:0]  mx_s, my_s, p_s, q_s;
  logic signed [COORD_W-1:0]  dn, dd, dd_abs;
  logic signed [CORDIC_W-1:0] sx, sy, x_nx, y_nx;
  logic signed [ANG_W-1:0]    z_nx;
  logic                       general;

  // midpoint and direction of the segment
  always_comb begin
    sum_xx  = {1'b0, seg.xs} + {1'b0, seg.xe};
    sum_yy  = {1'b0, seg.ys} + {1'b0, seg.ye};
    mx_s    = $signed({{(COORD_W-10){1'b0}}, sum_xx[10:1]});
    my_s    = $signed({{(COORD_W-10){1'b0}}, sum_yy[10:1]});
    p_s     = $signed({{(COORD_W-10){1'b0}}, seg.xe}) - $signed({{(COORD_W-10){1'b0}}, seg.xs});
    q_s     = $signed({{(COORD_W-10){1'b0}}, seg.ys}) - $signed({{(COORD_W-10){1'b0}}, seg.ye});
    general = (seg.xs != seg.xe) && (seg.ys != seg.ye);
    dn      = a2 - a0;
    dd      = a1 - a3;
    dd_abs  = dd[COORD_W-1] ? -dd : dd;
  end

  // one cordic vectoring step
  always_comb begin
    sx   = cx >>> cidx;
    sy   = cy >>> cidx;
    x_nx = cx;
    y_nx = cy;
    z_nx = z;
    if (cy > 0) begin
      x_nx = cx + sy;
      y_nx = cy - sx;
      z_nx = z + atan_tab(cidx);
    end else if (cy < 0) begin
      x_nx = cx - sy;
      y_nx = cy + sx;
      z_nx = z - atan_tab(cidx);
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: if (in_valid) state_next = F_NUM;
      F_NUM:  state_next = general ? F_D1GO : F_C1;
      F_D1GO: state_next = F_D1W;
      F_D1W:  if (div_rsp.done) state_next = F_D3GO;
      F_D3GO: state_next = F_D3W;
      F_D3W:  if (div_rsp.done) state_next = F_C1;
      F_C1:   state_next = F_C2;
      F_C2:   state_next = ((a0 != a2) && (a1 != a3)) ? F_ROT : F_PUSH;
      F_ROT:  if (cidx == CIDX_W'(CORDIC_STEPS - 1)) state_next = F_PUSH;
      F_PUSH: if (!q_full) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready      = (state == F_IDLE);
    push          = (state == F_PUSH) && !q_full;
    div_req.start = (state == F_D1GO) || (state == F_D3GO);
    div_req.num   = (state == F_D3GO) ? NUM_W'(n3) : NUM_W'(n1);
    div_req.den   = DEN_W'(q_s);
    div_req.steps = STEP_W'(FRONT_DIV_STEPS);
    push_entry.line.dx  = a0 - a2;
    push_entry.line.dy  = a1 - a3;
    push_entry.line.c   = c;
    push_entry.line.ang = ang;
    push_entry.last     = seg.last;
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      F_IDLE: begin
        if (in_valid) seg <= in_seg;
      end
      F_NUM: begin
        n1 <= my_s * q_s - (mx_s + ONE_C) * p_s;
        n3 <= my_s * q_s + (EXT_S - mx_s) * p_s;
        if (seg.xs == seg.xe) begin
          a0 <= NEG1;
          a1 <= my_s;
          a2 <= EXT_S;
          a3 <= my_s;
        end else if (seg.ys == seg.ye) begin
          a0 <= mx_s;
          a1 <= '0;
          a2 <= mx_s;
          a3 <= EXT_S;
        end else begin
          a0 <= NEG1;
          a2 <= EXT_S;
        end
      end
      F_D1W: begin
        if (div_rsp.done) a1 <= COORD_W'(div_rsp.quo);
      end
      F_D3W: begin
        if (div_rsp.done) a3 <= COORD_W'(div_rsp.quo);
      end
      F_C1: begin
        cp <= C_W'(a0 * a3);
      end
      F_C2: begin
        c    <= cp - C_W'(a1 * a2);
        cidx <= '0;
        z    <= '0;
        neg  <= dn[COORD_W-1] ^ dd[COORD_W-1];
        cx   <= CORDIC_W'(dd_abs) <<< CORDIC_SCALE;
        cy   <= CORDIC_W'(dn[COORD_W-1] ? -dn : dn) <<< CORDIC_SCALE;
        if (a0 == a2) begin
          ang <= '0;
        end else if (a1 == a3) begin
          ang <= ANG_W'(ONE_RADIAN);
        end
      end
      F_ROT: begin
        cx   <= x_nx;
        cy   <= y_nx;
        z    <= z_nx;
        cidx <= cidx + 1'b1;
        if (cidx == CIDX_W'(CORDIC_STEPS - 1)) ang <= neg ? -z_nx : z_nx;
      end
      default: begin
      end
    endcase
  end

endmodule

### design/bic_queue.sv
module bic_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  bic_pkg::qentry_t push_entry,
  output logic             full,
  input  logic             pop,
  output bic_pkg::qentry_t head,
  output logic             empty
);
  import bic_pkg::*;

  qentry_t        entries [QDEPTH];
  logic [QAW-1:0] wr_ptr, rd_ptr;
  logic [QAW:0]   fill;

  assign full  = (fill == (QAW+1)'(QDEPTH));
  assign empty = (fill == '0);
  assign head  = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_entry;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) fill <= fill + 1'b1;
      else if (pop && !push) fill <= fill - 1'b1;
    end
  end

endmodule

### design/bic_back.sv
module bic_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  bic_pkg::qentry_t  q_head,
  output logic              q_pop,
  input  logic [10:0]       image_width,
  input  logic [10:0]       image_height,
  output logic              out_valid,
  input  logic              out_ready,
  output bic_pkg::result_t  out_res,
  output bic_pkg::div_req_t div_req,
  input  bic_pkg::div_rsp_t div_rsp
);
  import bic_pkg::*;

  back_state_t state, state_next;

  line_t                     extended_lines [MAX_LINES];
  line_t                     rd, la, lb;
  logic [LINE_AW-1:0]        rd_addr;
  logic [CNT_W-1:0]          line_count, i, j;
  logic                      dropped;
  logic [2:0]                mstep;
  logic signed [PROD_W-1:0]  prod, hold;
  logic signed [DEN_W-1:0]   den;
  logic signed [NUM_W-1:0]   t1, t2, px;
  logic [SUM_W-1:0]          sum_x, sum_y;
  logic [PCNT_W-1:0]         accepted_count;
  logic [9:0]                cx, cy;

  logic signed [C_W-1:0]     mul_a;
  logic signed [COORD_W-1:0] mul_b;
  logic signed [ANG_W:0]     ang_diff, ang_abs;
  logic                      ang_reject;
  logic signed [NUM_W-1:0]   w_ext, h_ext, py;
  logic                      in_image;
  logic [9:0]                quo_sat;

  // angle test, image test and saturation
  always_comb begin
    ang_diff   = {la.ang[ANG_W-1], la.ang} - {rd.ang[ANG_W-1], rd.ang};
    ang_abs    = ang_diff[ANG_W] ? -ang_diff : ang_diff;
    ang_reject = ang_abs > (ANG_W+1)'(ANGLE_LIMIT);
    w_ext      = $signed({{(NUM_W-11){1'b0}}, image_width});
    h_ext      = $signed({{(NUM_W-11){1'b0}}, image_height});
    py         = div_rsp.quo;
    in_image   = (px > 0) && (px < w_ext) && (py > 0) && (py < h_ext);
    quo_sat    = (div_rsp.quo > 1023) ? 10'd1023 : div_rsp.quo[9:0];
  end

  // operand select of the shared multiplier
  always_comb begin
    case (mstep)
      3'd0: begin mul_a = C_W'(lb.dy); mul_b = la.dx; end
      3'd1: begin mul_a = C_W'(la.dy); mul_b = lb.dx; end
      3'd2: begin mul_a = la.c;        mul_b = lb.dx; end
      3'd3: begin mul_a = lb.c;        mul_b = la.dx; end
      3'd4: begin mul_a = la.c;        mul_b = lb.dy; end
      3'd5: begin mul_a = lb.c;        mul_b = la.dy; end
      default: begin mul_a = '0;       mul_b = '0;    end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE:  if (!q_empty && q_head.last) state_next = B_START;
      B_START: state_next = B_RDI;
      B_RDI:   state_next = B_GETI;
      B_GETI:  state_next = B_RDJ;
      B_RDJ:   state_next = B_GETJ;
      B_GETJ:  state_next = ((j == i) || ang_reject) ? B_NEXT : B_MUL;
      B_MUL:   if (mstep == 3'd6) state_next = B_CHK;
      B_CHK:   state_next = (den == '0) ? B_NEXT : B_DXGO;
      B_DXGO:  state_next = B_DXW;
      B_DXW:   if (div_rsp.done) state_next = B_DYGO;
      B_DYGO:  state_next = B_DYW;
      B_DYW:   if (div_rsp.done) state_next = B_NEXT;
      B_NEXT: begin
        if (j + 1'b1 < line_count) state_next = B_RDJ;
        else if (i + 1'b1 < line_count) state_next = B_RDI;
        else state_next = B_MEANX;
      end
      B_MEANX: state_next = (accepted_count == '0) ? B_OUT : B_MXW;
      B_MXW:   if (div_rsp.done) state_next = B_MYGO;
      B_MYGO:  state_next = B_MYW;
      B_MYW:   if (div_rsp.done) state_next = B_OUT;
      B_OUT:   if (!out_valid || out_ready) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop   = (state == B_IDLE) && !q_empty;
    rd_addr = (state == B_RDI) ? i[LINE_AW-1:0] : j[LINE_AW-1:0];
    div_req.start = 1'b0;
    div_req.num   = t1;
    div_req.den   = den;
    div_req.steps = STEP_W'(NUM_W);
    case (state)
      B_DXGO: begin
        div_req.start = 1'b1;
      end
      B_DYGO: begin
        div_req.start = 1'b1;
        div_req.num   = t2;
      end
      B_MEANX, B_MYGO: begin
        div_req.start = (state == B_MYGO) || (accepted_count != '0);
        div_req.num   = (state == B_MYGO) ? $signed({{(NUM_W-SUM_W){1'b0}}, sum_y})
                                          : $signed({{(NUM_W-SUM_W){1'b0}}, sum_x});
        div_req.den   = $signed({{(DEN_W-PCNT_W){1'b0}}, accepted_count});
        div_req.steps = STEP_W'(SUM_W);
      end
      default: begin
      end
    endcase
  end

  // line memory
  always_ff @(posedge clk) begin
    if (q_pop && (line_count < CNT_W'(MAX_LINES)))
      extended_lines[line_count[LINE_AW-1:0]] <= q_head.line;
    rd <= extended_lines[rd_addr];
  end

  // control counters and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      line_count <= '0;
      dropped    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (q_pop) begin
        if (line_count < CNT_W'(MAX_LINES)) line_count <= line_count + 1'b1;
        else dropped <= 1'b1;
      end
      if ((state == B_OUT) && (!out_valid || out_ready)) begin
        out_valid        <= 1'b1;
        out_res.cx       <= cx;
        out_res.cy       <= cy;
        out_res.count    <= accepted_count;
        out_res.overflow <= dropped;
        line_count       <= '0;
        dropped          <= 1'b0;
      end
    end
  end

  // pair pass datapath
  always_ff @(posedge clk) begin
    case (state)
      B_START: begin
        i              <= '0;
        sum_x          <= '0;
        sum_y          <= '0;
        accepted_count <= '0;
      end
      B_GETI: begin
        la <= rd;
        j  <= '0;
      end
      B_GETJ: begin
        lb    <= rd;
        mstep <= '0;
      end
      B_MUL: begin
        prod  <= mul_a * mul_b;
        mstep <= mstep + 1'b1;
        if (mstep == 3'd1 || mstep == 3'd3 || mstep == 3'd5) hold <= prod;
        if (mstep == 3'd2) den <= DEN_W'(hold - prod);
        if (mstep == 3'd4) t1  <= NUM_W'(hold - prod);
        if (mstep == 3'd6) t2  <= NUM_W'(hold - prod);
      end
      B_DXW: begin
        if (div_rsp.done) px <= div_rsp.quo;
      end
      B_DYW: begin
        if (div_rsp.done && in_image) begin
          sum_x          <= sum_x + px[SUM_W-1:0];
          sum_y          <= sum_y + py[SUM_W-1:0];
          accepted_count <= accepted_count + 1'b1;
        end
      end
      B_NEXT: begin
        if (j + 1'b1 < line_count) j <= j + 1'b1;
        else i <= i + 1'b1;
      end
      B_MEANX: begin
        cx <= '0;
        cy <= '0;
      end
      B_MXW: begin
        if (div_rsp.done) cx <= quo_sat;
      end
      B_MYW: begin
        if (div_rsp.done) cy <= quo_sat;
      end
      default: begin
      end
    endcase
  end

endmodule

### design/bisector_intersection_centroid.sv
// Perpendicular-bisector intersection centroid.
// Input stream: one line segment per beat on s_tdata, s_tlast marks the last
// segment of a set. Each segment's bisector is built by the front end (two
// 23-step divides for a slanted segment, a 16-step cordic for its angle when
// it is neither level nor upright) and queued. The back end stores up to 64
// lines; further segments of a set are dropped and flagged. After the last
// segment every ordered pair of distinct, non-parallel lines within the
// angle limit is intersected by two 58-step divides; two 23-step divides on
// the same divider give the mean. One result beat on m_tdata follows
// each set: centroid x, y, point count and the overflow flag.
// While the pass runs the front end keeps taking segments until the two-entry
// queue fills, then s_tready drops. The result waits in an output register if
// m_tready is low; the next set's result holds the back end until it is taken.
// Reset empties the queue and the line buffer and restores image width 640
// and height 480. Registers are written over the apb port at 0 and 4.
module bisector_intersection_centroid (
  input  logic        clk,
  input  logic        rst,
  // apb config
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // segment stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // x_start, y_start, x_end, y_end
  input  logic        s_tlast,  // last_segment
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata   // centroid_x, centroid_y, point_count, overflow
);
  import bic_pkg::*;

  logic [10:0] image_width, image_height;
  seg_t        seg;
  logic        push, q_full, q_pop, q_empty;
  qentry_t     push_entry, q_head;
  div_req_t    fdiv_req, bdiv_req;
  div_rsp_t    fdiv_rsp, bdiv_rsp;
  result_t     res;

  // configuration registers
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 11'd640;
      image_height <= 11'd480;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2]) image_height <= pwdata[10:0];
      else image_width <= pwdata[10:0];
    end
  end
  assign prdata = paddr[2] ? {21'b0, image_height} : {21'b0, image_width};

  // stream unpack and pack
  always_comb begin
    seg.xs   = s_tdata[9:0];
    seg.ys   = s_tdata[19:10];
    seg.xe   = s_tdata[29:20];
    seg.ye   = s_tdata[39:30];
    seg.last = s_tlast;
  end
  assign m_tdata = {7'b0, res.overflow, res.count, res.cy, res.cx};

  bic_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_seg     (seg),
    .push       (push),
    .push_entry (push_entry),
    .q_full     (q_full),
    .div_req    (fdiv_req),
    .div_rsp    (fdiv_rsp)
  );

  bic_div u_front_div (
    .clk (clk),
    .rst (rst),
    .req (fdiv_req),
    .rsp (fdiv_rsp)
  );

  bic_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head),
    .empty      (q_empty)
  );

  bic_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .image_width  (image_width),
    .image_height (image_height),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_res      (res),
    .div_req      (bdiv_req),
    .div_rsp      (bdiv_rsp)
  );

  bic_div u_back_div (
    .clk (clk),
    .rst (rst),
    .req (bdiv_req),
    .rsp (bdiv_rsp)
  );

endmodule
